// ===== hdl/isrt_pkg.sv =====
// shared types and constants for the insertion sorter
package isrt_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             count_t;

  // per-cycle command broadcast along the chain
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// ===== hdl/insertion_sorter.sv =====
// insertion sorter: one value per cycle, while not busy, into a chain of compare-and-shift cells
// a beat is inserted at its accepting edge; a last beat starts a drain in the next
// cycle, and results leave one per cycle through an output register, the first strobe
// following the last beat through the state register and then the output register
// throughput: one beat per cycle while filling; busy holds through the drain
// reset: synchronous active-low rst_n clears valid bits, count, flag and strobe; the
// receiver cannot stall: each result is shown for exactly one cycle
module insertion_sorter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  isrt_pkg::data_t     in_value,
  input  logic                in_last_in,
  output logic                out_valid,
  output isrt_pkg::data_t     out_sorted_value,
  output logic                out_last_out,
  output logic                out_overflow
);

  isrt_pkg::state_t     state_r, state_nxt;
  isrt_pkg::count_t     count_r, count_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 out_valid_r;
  logic                 out_last_r;
  logic                 out_ovf_r;
  isrt_pkg::data_t      out_value_r;
  isrt_pkg::cell_ctrl_t ctrl;
  logic                 accept;
  logic                 full;

  isrt_pkg::data_t cell_value [isrt_pkg::MAX_ITEMS];
  logic            cell_valid [isrt_pkg::MAX_ITEMS];
  logic            cell_take  [isrt_pkg::MAX_ITEMS];

  assign busy   = (state_r == isrt_pkg::ST_DRAIN);
  assign accept = start && !busy;
  assign full   = (count_r == isrt_pkg::CNT_W'(isrt_pkg::MAX_ITEMS));

  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = busy;

  genvar i;
  generate
    for (i = 0; i < isrt_pkg::MAX_ITEMS; i++) begin : g_cell
      isrt_pkg::data_t prev_value, next_value;
      logic            prev_valid, prev_take, next_valid;

      if (i == 0) begin : g_head
        assign prev_value = '0;
        assign prev_valid = 1'b0;
        assign prev_take  = 1'b0;
      end else begin : g_body
        assign prev_value = cell_value[i-1];
        assign prev_valid = cell_valid[i-1];
        assign prev_take  = cell_take[i-1];
      end

      if (i == isrt_pkg::MAX_ITEMS - 1) begin : g_tail
        assign next_value = '0;
        assign next_valid = 1'b0;
      end else begin : g_inner
        assign next_value = cell_value[i+1];
        assign next_valid = cell_valid[i+1];
      end

      isrt_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .key        (in_value),
        .prev_value (prev_value),
        .prev_valid (prev_valid),
        .prev_take  (prev_take),
        .next_value (next_value),
        .next_valid (next_valid),
        .value      (cell_value[i]),
        .valid      (cell_valid[i]),
        .take       (cell_take[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    unique case (state_r)
      isrt_pkg::ST_FILL: begin
        if (accept) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
          if (in_last_in) begin
            state_nxt = isrt_pkg::ST_DRAIN;
          end
        end
      end
      isrt_pkg::ST_DRAIN: begin
        count_nxt = count_r - 1'b1;
        if (count_r == isrt_pkg::CNT_W'(1)) begin
          state_nxt   = isrt_pkg::ST_FILL;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = isrt_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // head cell feeds the result register while the chain shifts down
    out_value_r <= cell_value[0];
    out_last_r  <= (count_r == isrt_pkg::CNT_W'(1));
    out_ovf_r   <= dropped_r;
    if (!rst_n) begin
      state_r     <= isrt_pkg::ST_FILL;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= busy;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ===== hdl/isrt_cell.sv =====
// one cell of the systolic insertion chain
module isrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  isrt_pkg::cell_ctrl_t ctrl,
  input  isrt_pkg::data_t     key,
  input  isrt_pkg::data_t     prev_value,
  input  logic                prev_valid,
  input  logic                prev_take,
  input  isrt_pkg::data_t     next_value,
  input  logic                next_valid,
  output isrt_pkg::data_t     value,
  output logic                valid,
  output logic                take
);

  isrt_pkg::data_t value_r;
  isrt_pkg::data_t value_nxt;
  logic            valid_r;
  logic            valid_nxt;

  // strict compare keeps equal keys in arrival order
  assign take  = !valid_r || (key < value_r);
  assign value = value_r;
  assign valid = valid_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      value_nxt = next_value;
      valid_nxt = next_valid;
    end else if (ctrl.ins) begin
      if (prev_take) begin
        value_nxt = prev_value;
        valid_nxt = prev_valid;
      end else if (take) begin
        value_nxt = key;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== tb/insertion_sorter_tb.sv =====
// self-checking testbench for the insertion sorter: directed table, then random sets
module insertion_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              RAND_BEATS = 280;
  localparam isrt_pkg::data_t VAL_MIN    = 32'sh8000_0000;
  localparam isrt_pkg::data_t VAL_MAX    = 32'sh7fff_ffff;

  typedef struct packed {
    isrt_pkg::data_t value;
    logic            last;
    logic            typed;
    isrt_pkg::data_t want;
  } dir_row_t;

  typedef struct {
    isrt_pkg::data_t value;
    logic            last;
    logic            ovf;
  } sorted_beat_t;

  localparam int N_DIR = 22;
  // typed rows are single-element sets, so the one result is the value itself
  localparam dir_row_t DIR_TBL [0:N_DIR-1] = '{
    '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
    '{VAL_MAX, 1'b1, 1'b1, VAL_MAX},
    '{32'sd0,  1'b1, 1'b1, 32'sd0},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1},
    '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
    '{VAL_MIN, 1'b1, 1'b0, 32'sd0},
    '{32'sd5,  1'b0, 1'b0, 32'sd0},
    '{32'sd3,  1'b0, 1'b0, 32'sd0},
    '{32'sd1,  1'b0, 1'b0, 32'sd0},
    '{-32'sd2, 1'b0, 1'b0, 32'sd0},
    '{-32'sd9, 1'b1, 1'b0, 32'sd0},
    '{32'sd7,  1'b0, 1'b0, 32'sd0},
    '{32'sd7,  1'b0, 1'b0, 32'sd0},
    '{-32'sd7, 1'b0, 1'b0, 32'sd0},
    '{32'sd7,  1'b1, 1'b0, 32'sd0},
    '{32'sd1,  1'b0, 1'b0, 32'sd0},
    '{-32'sd1, 1'b0, 1'b0, 32'sd0},
    '{VAL_MIN, 1'b0, 1'b0, 32'sd0},
    '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
    '{32'sd0,  1'b1, 1'b0, 32'sd0},
    '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
    '{32'shAAAA_AAAA, 1'b1, 1'b0, 32'sd0}
  };

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            start      = 1'b0;
  isrt_pkg::data_t in_value   = '0;
  logic            in_last_in = 1'b0;
  logic            busy;
  logic            out_valid;
  isrt_pkg::data_t out_sorted_value;
  logic            out_last_out;
  logic            out_overflow;

  // shadow of the beat being offered, so the typed expectation travels with it
  logic            cur_typed  = 1'b0;
  isrt_pkg::data_t cur_want   = '0;

  isrt_pkg::data_t held_q [$];
  logic            set_dropped = 1'b0;
  sorted_beat_t    pending_q [$];
  sorted_beat_t    got;

  int errors        = 0;
  int beats_in      = 0;
  int sets_closed   = 0;
  int results_seen  = 0;
  int overflow_runs = 0;

  insertion_sorter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // insert behind equal values; a full store drops the value and marks the set
  task automatic sort_beat(isrt_pkg::data_t v, logic last, logic typed,
                           isrt_pkg::data_t want);
    int j;
    sorted_beat_t r;
    beats_in++;
    if (held_q.size() >= isrt_pkg::MAX_ITEMS) begin
      set_dropped = 1'b1;
    end else begin
      j = held_q.size();
      while (j > 0 && v < held_q[j-1]) j--;
      held_q.insert(j, v);
    end
    if (last) begin
      sets_closed++;
      if (typed) begin
        r.value = want;
        r.last  = 1'b1;
        r.ovf   = 1'b0;
        pending_q.push_back(r);
      end else begin
        foreach (held_q[k]) begin
          r.value = held_q[k];
          r.last  = (k == held_q.size() - 1);
          r.ovf   = set_dropped;
          pending_q.push_back(r);
        end
      end
      held_q.delete();
      set_dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (out_last_out && out_overflow) overflow_runs++;
        if (pending_q.size() == 0) begin
          $error("result with none expected: sorted_value %0d", out_sorted_value);
          errors++;
        end else begin
          got = pending_q.pop_front();
          if (out_sorted_value !== got.value) begin
            $error("sorted_value: expected %0d, got %0d", got.value, out_sorted_value);
            errors++;
          end
          if (out_last_out !== got.last) begin
            $error("last_out: expected %0b, got %0b", got.last, out_last_out);
            errors++;
          end
          if (out_overflow !== got.ovf) begin
            $error("overflow: expected %0b, got %0b", got.ovf, out_overflow);
            errors++;
          end
        end
      end
      if (start && !busy) sort_beat(in_value, in_last_in, cur_typed, cur_want);
    end
  end

  task automatic send_beat(isrt_pkg::data_t v, logic last, logic typed,
                           isrt_pkg::data_t want, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_value   <= v;
    in_last_in <= last;
    cur_typed  <= typed;
    cur_want   <= want;
    // busy only moves on a rising edge, so look at it mid-cycle
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic isrt_pkg::data_t rand_value();
    case ($urandom_range(0, 3))
      0:       return isrt_pkg::data_t'(int'($urandom_range(0, 15)) - 8);
      1:       return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      default: return isrt_pkg::data_t'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int set_no;
    int len;
    int pct;
    int guard;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TBL[i])
      send_beat(DIR_TBL[i].value, DIR_TBL[i].last, DIR_TBL[i].typed, DIR_TBL[i].want, 6);

    // mostly short sets; one exactly full and one overflowing set early on
    sent   = 0;
    set_no = 0;
    while (sent < RAND_BEATS) begin
      if (set_no == 1)
        len = isrt_pkg::MAX_ITEMS;
      else if (set_no == 3)
        len = isrt_pkg::MAX_ITEMS + $urandom_range(1, 5);
      else if ($urandom_range(0, 24) == 0)
        len = isrt_pkg::MAX_ITEMS + $urandom_range(0, 3);
      else
        len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        pct = (sent < RAND_BEATS / 3) ? 6 : (sent < 2 * RAND_BEATS / 3) ? 81 : 0;
        send_beat(rand_value(), k == len - 1, 1'b0, '0, pct);
        sent++;
      end
      set_no++;
    end
    start <= 1'b0;

    guard = 0;
    while (pending_q.size() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (isrt_pkg::MAX_ITEMS + 8) @(posedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d sorted results never arrived", pending_q.size());
      errors++;
    end

    $display("%0d beats in %0d sets, %0d sorted results checked", beats_in, sets_closed,
             results_seen);
    $display("%0d runs came out with the overflow flag set", overflow_runs);
    if (errors == 0)
      $display("insertion_sorter: match");
    else
      $display("insertion_sorter: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("insertion_sorter: mismatch");
    $finish;
  end

endmodule
